/* src/pwli_pkg.sv */
// Shared constants, field widths and the table entry type for the
// piecewise linear table interpolator. No dependencies.
`default_nettype none

package pwli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // Field widths
    localparam int IDX_W  = 6;
    localparam int LEN_W  = 7;
    localparam int BP_W   = 17;
    localparam int VAL_W  = 32;
    localparam int PROG_W = 19;

    // Datapath widths
    localparam int DV_W      = VAL_W + 1;           // value difference
    localparam int PROD_W    = BP_W + DV_W;         // signed product
    localparam int DIV_W     = PROD_W - 1;          // product magnitude
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int QMAG_W    = VAL_W + 1;           // quotient never exceeds |dv|
    localparam int SUM_W     = VAL_W + 3;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;
    localparam logic [LEN_W-1:0] LEN_MIN   = 7'd2;

    localparam logic signed [PROG_W-1:0] PROG_ONE  = 19'sd65536;
    localparam logic signed [VAL_W-1:0]  VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [BP_W-1:0]         bp;
        logic signed [VAL_W-1:0] val;
    } table_entry_t;

endpackage

`default_nettype wire

/* src/pwli_table.sv */
// Breakpoint/value table: one write port, one registered read port.
// Depends on pwli_pkg.
`default_nettype none

module pwli_table (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [pwli_pkg::ADDR_W-1:0] wr_addr,
    input  wire pwli_pkg::table_entry_t      wr_entry,
    input  wire logic                        rd_en,
    input  wire logic [pwli_pkg::ADDR_W-1:0] rd_addr,
    output pwli_pkg::table_entry_t           rd_entry
);
    import pwli_pkg::*;

    table_entry_t mem [TABLE_DEPTH];
    table_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

/* src/pwli_divider.sv */
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pwli_pkg.
`default_nettype none

module pwli_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pwli_pkg::DIV_W-1:0] dividend,
    input  wire logic [pwli_pkg::BP_W-1:0]  divisor,
    output logic                            done,
    output logic [pwli_pkg::DIV_W-1:0]      quotient
);
    import pwli_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [BP_W-1:0]      rem_reg, rem_next;
    logic [BP_W-1:0]      dvsr_reg, dvsr_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;

    logic [BP_W:0] shifted;
    logic [BP_W:0] diff;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvsr_reg};
    assign ge      = (shifted >= {1'b0, dvsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            rem_next  = '0;
            dvsr_next = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[BP_W-1:0] : shifted[BP_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* src/piecewise_linear_table_interp.sv */
// Top level of the 1-D piecewise linear table interpolator: sequencer,
// multiplier and result stage. Depends on pwli_pkg, pwli_table, pwli_divider.
//
// Usage:
//   Input channel (in_valid / in_stall): action 0 loads entry_index with
//   entry_breakpoint and entry_value (no result); action 1 asks
//   a query at query_progress and yields one result on the output channel
//   (out_valid / out_stall) carrying result_value and segment_index.
//   Config channel (cfg_valid / cfg_ready) writes table_length; it is
//   ready only while the block is idle.
//   A query scans entries one at a time (1..table_length of them) through
//   the table's single read port, then does one multiply and a 49-bit
//   bit-serial divide before out_valid. in_stall is high for that whole
//   time. A hit on entry 0 or a run off the table end skips the multiply
//   and divide.
//   The result sits in an output register; a new item is accepted while it
//   waits. If the receiver stalls when the next result is ready, the
//   sequencer holds until the register frees.
//   Reset clears the control state, sets table_length to 64 and the running
//   minimum to the largest positive value; table contents are undefined.
`default_nettype none

module piecewise_linear_table_interp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               action,
    input  wire logic [pwli_pkg::IDX_W-1:0]         entry_index,
    input  wire logic [pwli_pkg::BP_W-1:0]          entry_breakpoint,
    input  wire logic signed [pwli_pkg::VAL_W-1:0]  entry_value,
    input  wire logic signed [pwli_pkg::PROG_W-1:0] query_progress,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [pwli_pkg::VAL_W-1:0]       result_value,
    output logic [pwli_pkg::IDX_W-1:0]              segment_index,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pwli_pkg::LEN_W-1:0]         cfg_data
);
    import pwli_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIVGO = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_SUM   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // Control registers
    logic [2:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic signed [VAL_W-1:0] min_reg, min_next;
    logic                    out_valid_reg, out_valid_next;

    // Payload registers
    logic signed [PROG_W-1:0] q_reg, q_next;
    table_entry_t             prev_reg, prev_next;
    logic [BP_W-1:0]          dq_reg, dq_next;
    logic signed [DV_W-1:0]   dv_reg, dv_next;
    logic [BP_W-1:0]          dvsr_reg, dvsr_next;
    logic signed [VAL_W-1:0]  vlo_reg, vlo_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [VAL_W-1:0]  res_val_reg, res_val_next;
    logic [ADDR_W-1:0]        res_seg_reg, res_seg_next;
    logic signed [VAL_W-1:0]  out_val_reg, out_val_next;
    logic [IDX_W-1:0]         out_seg_reg, out_seg_next;

    // Table and divider hookup
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] rd_addr;
    table_entry_t      wr_entry, rd_entry;
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_dividend, div_quot;

    // Datapath terms
    logic                     in_accept, out_free, load_ok, hit;
    logic [LEN_W-1:0]         len_m1;
    logic [ADDR_W-1:0]        last_idx;
    logic [BP_W:0]            bp_diff;
    logic signed [PROD_W:0]   prod_full;
    logic                     prod_neg;
    logic [PROD_W-1:0]        prod_mag;
    logic [QMAG_W-1:0]        qmag;
    logic signed [QMAG_W:0]   qsigned;
    logic signed [SUM_W-1:0]  sum, floored, min_ext, max_ext;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_ok   = (int'(entry_index) < TABLE_DEPTH);

    // Effective length clamped to [2, TABLE_DEPTH]
    always_comb
    begin
        if (len_reg < LEN_MIN)
        begin
            len_m1 = LEN_MIN - 1'b1;
        end
        else if (int'(len_reg) > TABLE_DEPTH)
        begin
            len_m1 = LEN_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            len_m1 = len_reg - 1'b1;
        end
    end
    assign last_idx = len_m1[ADDR_W-1:0];

    assign hit       = ($signed({2'b00, rd_entry.bp}) >= q_reg);
    assign bp_diff   = {1'b0, rd_entry.bp} - {1'b0, prev_reg.bp};
    assign prod_full = (PROD_W+1)'($signed({1'b0, dq_reg})) * (PROD_W+1)'(dv_reg);
    assign prod_neg  = prod_reg[PROD_W-1];
    assign prod_mag  = prod_neg ? PROD_W'(-prod_reg) : prod_reg;
    assign div_dividend = prod_mag[DIV_W-1:0];

    // Quotient magnitude is bounded by |vhi - vlo| since q - lo <= hi - lo
    assign qmag    = div_quot[QMAG_W-1:0];
    assign qsigned = prod_neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    assign sum     = {{(SUM_W-VAL_W){vlo_reg[VAL_W-1]}}, vlo_reg}
                   + {{(SUM_W-QMAG_W-1){qsigned[QMAG_W]}}, qsigned};
    assign min_ext = {{(SUM_W-VAL_W){min_reg[VAL_W-1]}}, min_reg};
    assign max_ext = {{(SUM_W-VAL_W){1'b0}}, VALUE_MAX};
    assign floored = (sum < min_ext) ? min_ext : sum;

    assign wr_en    = in_accept && (action == ACT_LOAD) && load_ok;
    assign wr_entry = '{bp: entry_breakpoint, val: entry_value};

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        len_next       = len_reg;
        min_next       = min_reg;
        out_valid_next = out_valid_reg;
        q_next         = q_reg;
        prev_next      = prev_reg;
        dq_next        = dq_reg;
        dv_next        = dv_reg;
        dvsr_next      = dvsr_reg;
        vlo_next       = vlo_reg;
        prod_next      = prod_reg;
        res_val_next   = res_val_reg;
        res_seg_next   = res_seg_reg;
        out_val_next   = out_val_reg;
        out_seg_next   = out_seg_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_idx_reg + 1'b1;
        div_start      = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            len_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (action == ACT_QUERY)
                    begin
                        q_next     = (query_progress > PROG_ONE) ? PROG_ONE : query_progress;
                        state_next = S_ISSUE;
                    end
                    else if (load_ok && (entry_value < min_reg))
                    begin
                        min_next = entry_value;
                    end
                end
            end
            S_ISSUE:
            begin
                rd_en         = 1'b1;
                rd_addr       = '0;
                scan_idx_next = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit && (scan_idx_reg == '0))
                begin
                    res_val_next = rd_entry.val;
                    res_seg_next = scan_idx_reg;
                    state_next   = S_DONE;
                end
                else if (hit)
                begin
                    // q > lo here, so q - lo fits 17 bits unsigned
                    dq_next      = q_reg[BP_W-1:0] - prev_reg.bp;
                    dv_next      = {rd_entry.val[VAL_W-1], rd_entry.val}
                                 - {prev_reg.val[VAL_W-1], prev_reg.val};
                    dvsr_next    = ($signed(bp_diff) < $signed((BP_W+1)'(1)))
                                 ? BP_W'(1) : bp_diff[BP_W-1:0];
                    vlo_next     = prev_reg.val;
                    res_seg_next = scan_idx_reg;
                    state_next   = S_MUL;
                end
                else if (scan_idx_reg == last_idx)
                begin
                    res_val_next = rd_entry.val;
                    res_seg_next = scan_idx_reg;
                    state_next   = S_DONE;
                end
                else
                begin
                    prev_next     = rd_entry;
                    scan_idx_next = scan_idx_reg + 1'b1;
                    rd_en         = 1'b1;
                end
            end
            S_MUL:
            begin
                prod_next  = prod_full[PROD_W-1:0];
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                res_val_next = (floored > max_ext) ? VALUE_MAX : floored[VAL_W-1:0];
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_val_reg;
                    out_seg_next   = IDX_W'(res_seg_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_idx_reg  <= '0;
            len_reg       <= LEN_RESET;
            min_reg       <= VALUE_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            len_reg       <= len_next;
            min_reg       <= min_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        prev_reg    <= prev_next;
        dq_reg      <= dq_next;
        dv_reg      <= dv_next;
        dvsr_reg    <= dvsr_next;
        vlo_reg     <= vlo_next;
        prod_reg    <= prod_next;
        res_val_reg <= res_val_next;
        res_seg_reg <= res_seg_next;
        out_val_reg <= out_val_next;
        out_seg_reg <= out_seg_next;
    end

    pwli_table u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (entry_index[ADDR_W-1:0]),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    pwli_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dvsr_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign result_value  = out_val_reg;
    assign segment_index = out_seg_reg;

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg <= last_idx))
        else $error("scan index past table length");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide phase");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (action == ACT_QUERY)) |=> (state_reg == S_ISSUE))
        else $error("accepted query did not start a scan");

    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> (out_valid && (state_reg == S_IDLE)))
        else $error("finished result not presented");
`endif

endmodule

`default_nettype wire
